// ===== rtl/dist_pkg.sv =====
// ----------------------------------------------------------------------------
// Disjoint interval set table package
// Operation and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package dist_pkg;

    // Operation codes carried in the input tuser.
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_INVERT = 3'd2,
        OP_FILL   = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_LIST   = 3'd5
    } t_op;

    // Status codes returned in the result.
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_OVERLAP       = 3'd1,
        ST_NOT_CONTAINED = 3'd2,
        ST_FULL          = 3'd3,
        ST_ORDER         = 3'd4
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_REM_SCAN,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_INS_PUT,
        S_INV_SCAN,
        S_LIST,
        S_RESP
    } t_state;

    // Fixed field widths of the stream payload.
    localparam int FIELD_BITS = 31;
    localparam int COUNT_BITS = 5;

endpackage

// ===== rtl/disjoint_interval_set_table.sv =====
// ----------------------------------------------------------------------------
// Disjoint interval set table
// Sorted table of disjoint inclusive ranges with insert, remove, invert,
// fill, clear and list operations.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A sequencer walks the table through a
// single registered read port, one entry per cycle, and moves entries one per
// cycle when a range is inserted or deleted. The moves continue from where the
// scan stopped, so they add no more than the entries left above that point.
// Invert makes two passes over the table. Fill, clear, unused codes and a
// range with low above high go straight to the result. List gives one result
// transaction per cycle while the output side accepts. The next input
// transaction is taken while the last result still waits.
module disjoint_interval_set_table
    import dist_pkg::*;
#(
    parameter int MAX_RANGES = 16,
    parameter int VALUE_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // range_low[30:0], range_high[61:31]
    input  logic [2:0]  s_axis_tuser,   // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // status, range_count, entry_low, entry_high
    output logic        m_axis_tuser,   // entry_valid
    output logic        m_axis_tlast
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int IW = $clog2(MAX_RANGES + 2);
    localparam int VW = VALUE_BITS;
    localparam logic [VW-1:0] VMAX = {VW{1'b1}};
    localparam logic [IW-1:0] MAXC = IW'(MAX_RANGES);

    t_state r_state, n_state;
    logic [IW-1:0] r_count, n_count, r_idx, n_idx, r_pos, n_pos, r_g, n_g;
    logic [VW-1:0] r_lo, n_lo, r_hi, n_hi, r_plow, n_plow, r_phigh, n_phigh;
    logic [VW-1:0] r_ilo, n_ilo, r_ihi, n_ihi, r_cur, n_cur;
    logic          r_hp, n_hp, r_done, n_done, r_pass, n_pass;
    t_status       r_status, n_status;
    logic          r_ov, n_ov, r_ev, n_ev, r_last, n_last;
    logic [2:0]    r_ost, n_ost;
    logic [IW-1:0] r_ocnt, n_ocnt;
    logic [VW-1:0] r_olo, n_olo, r_ohi, n_ohi;

    logic          we;
    logic [IW-1:0] waddr;
    logic [VW-1:0] wlow, whigh, rlow, rhigh;
    logic          out_free, in_acc;
    logic [VW-1:0] in_lo, in_hi;

    dist_table #(.MAX_RANGES(MAX_RANGES), .VALUE_BITS(VALUE_BITS)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr[AW-1:0]),
        .i_wlow  (wlow),
        .i_whigh (whigh),
        .i_raddr (n_idx[AW-1:0]),
        .o_rlow  (rlow),
        .o_rhigh (rhigh)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ov || m_axis_tready;
    assign in_lo    = VW'(s_axis_tdata[30:0]);
    assign in_hi    = VW'(s_axis_tdata[61:31]);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;    r_pos <= n_pos;    r_g <= n_g;
        r_lo <= n_lo;      r_hi <= n_hi;      r_plow <= n_plow;
        r_phigh <= n_phigh; r_ilo <= n_ilo;   r_ihi <= n_ihi;
        r_cur <= n_cur;    r_hp <= n_hp;      r_done <= n_done;
        r_pass <= n_pass;  r_status <= n_status;
        r_ev <= n_ev;      r_last <= n_last;  r_ost <= n_ost;
        r_ocnt <= n_ocnt;  r_olo <= n_olo;    r_ohi <= n_ohi;
    end

    // Sequencer: next state, table writes and result loading.
    always_comb begin
        n_state = r_state;  n_count = r_count;  n_idx = r_idx;
        n_pos = r_pos;      n_g = r_g;          n_lo = r_lo;
        n_hi = r_hi;        n_plow = r_plow;    n_phigh = r_phigh;
        n_ilo = r_ilo;      n_ihi = r_ihi;      n_cur = r_cur;
        n_hp = r_hp;        n_done = r_done;    n_pass = r_pass;
        n_status = r_status;
        n_ov = r_ov && !m_axis_tready;
        n_ev = r_ev;  n_last = r_last;  n_ost = r_ost;
        n_ocnt = r_ocnt;  n_olo = r_olo;  n_ohi = r_ohi;
        we = 1'b0;  waddr = r_idx;  wlow = rlow;  whigh = rhigh;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_lo = in_lo;  n_hi = in_hi;  n_idx = '0;
                    n_hp = 1'b0;   n_status = ST_OK;
                    n_cur = '0;    n_g = '0;  n_done = 1'b0;  n_pass = 1'b0;
                    n_state = S_RESP;
                    unique case (s_axis_tuser)
                        OP_INSERT: begin
                            if (in_lo > in_hi) n_status = ST_ORDER;
                            else n_state = S_INS_SCAN;
                        end
                        OP_REMOVE: begin
                            if (in_lo > in_hi) n_status = ST_ORDER;
                            else n_state = S_REM_SCAN;
                        end
                        OP_INVERT: n_state = S_INV_SCAN;
                        OP_FILL: begin
                            we = 1'b1;  waddr = '0;  wlow = '0;  whigh = VMAX;
                            n_count = IW'(1);
                        end
                        OP_CLEAR: n_count = '0;
                        OP_LIST: begin
                            if (r_count != '0) n_state = S_LIST;
                        end
                        default: ;
                    endcase
                end
            end

            S_INS_SCAN: begin
                if (r_idx < r_count && rlow < r_lo) begin
                    n_plow = rlow;  n_phigh = rhigh;  n_hp = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = S_RESP;
                    if ((r_hp && r_phigh >= r_lo) || (r_idx < r_count && rlow <= r_hi)) begin
                        n_status = ST_OVERLAP;
                    end else if (r_hp && r_phigh + 1'b1 == r_lo
                                 && r_idx < r_count && r_hi + 1'b1 == rlow) begin
                        // Joins both neighbors: widen the lower one, drop the upper.
                        we = 1'b1;  waddr = r_idx - 1'b1;  wlow = r_plow;  whigh = rhigh;
                        n_idx = r_idx + 1'b1;
                        n_state = S_SHIFT_DN;
                    end else if (r_hp && r_phigh + 1'b1 == r_lo) begin
                        we = 1'b1;  waddr = r_idx - 1'b1;  wlow = r_plow;  whigh = r_hi;
                    end else if (r_idx < r_count && r_hi + 1'b1 == rlow) begin
                        we = 1'b1;  wlow = r_lo;  whigh = rhigh;
                    end else if (r_count >= MAXC) begin
                        n_status = ST_FULL;
                    end else begin
                        n_pos = r_idx;  n_ilo = r_lo;  n_ihi = r_hi;
                        if (r_idx == r_count) n_state = S_INS_PUT;
                        else begin
                            n_idx = r_count - 1'b1;
                            n_state = S_SHIFT_UP;
                        end
                    end
                end
            end

            S_REM_SCAN: begin
                if (r_idx >= r_count) begin
                    n_status = ST_NOT_CONTAINED;
                    n_state = S_RESP;
                end else if (rlow <= r_lo && r_hi <= rhigh) begin
                    n_state = S_RESP;
                    if (rlow == r_lo && rhigh == r_hi) begin
                        n_idx = r_idx + 1'b1;
                        n_state = S_SHIFT_DN;
                    end else if (rlow == r_lo) begin
                        we = 1'b1;  wlow = r_hi + 1'b1;
                    end else if (rhigh == r_hi) begin
                        we = 1'b1;  whigh = r_lo - 1'b1;
                    end else if (r_count >= MAXC) begin
                        n_status = ST_FULL;
                    end else begin
                        // Split: keep the lower part here, insert the upper part after it.
                        we = 1'b1;  whigh = r_lo - 1'b1;
                        n_pos = r_idx + 1'b1;  n_ilo = r_hi + 1'b1;  n_ihi = rhigh;
                        if (r_idx + 1'b1 == r_count) n_state = S_INS_PUT;
                        else begin
                            n_idx = r_count - 1'b1;
                            n_state = S_SHIFT_UP;
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // Close the hole: entry at r_idx moves down by one.
            S_SHIFT_DN: begin
                if (r_idx < r_count) begin
                    we = 1'b1;  waddr = r_idx - 1'b1;
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_RESP;
                end
            end

            // Open a hole: entry at r_idx moves up by one.
            S_SHIFT_UP: begin
                we = 1'b1;  waddr = r_idx + 1'b1;
                if (r_idx == r_pos) n_state = S_INS_PUT;
                else n_idx = r_idx - 1'b1;
            end

            S_INS_PUT: begin
                we = 1'b1;  waddr = r_pos;  wlow = r_ilo;  whigh = r_ihi;
                n_count = r_count + 1'b1;
                n_state = S_RESP;
            end

            // Two passes over the table: count the gaps, then write them.
            S_INV_SCAN: begin
                if (r_idx < r_count && !r_done) begin
                    if (rlow > r_cur) begin
                        we = r_pass;  waddr = r_g;  wlow = r_cur;  whigh = rlow - 1'b1;
                        n_g = r_g + 1'b1;
                    end
                    if (rhigh == VMAX) n_done = 1'b1;
                    else n_cur = rhigh + 1'b1;
                    n_idx = r_idx + 1'b1;
                end else begin
                    if (!r_pass) begin
                        if (r_g + IW'(!r_done) > MAXC) begin
                            n_status = ST_FULL;
                            n_state = S_RESP;
                        end else begin
                            n_pass = 1'b1;  n_idx = '0;  n_g = '0;
                            n_cur = '0;     n_done = 1'b0;
                        end
                    end else begin
                        we = !r_done;  waddr = r_g;  wlow = r_cur;  whigh = VMAX;
                        n_count = r_g + IW'(!r_done);
                        n_state = S_RESP;
                    end
                end
            end

            S_LIST: begin
                if (out_free) begin
                    n_ov = 1'b1;  n_ev = 1'b1;  n_ost = ST_OK;  n_ocnt = r_count;
                    n_olo = rlow;  n_ohi = rhigh;
                    n_last = (r_idx + 1'b1 == r_count);
                    if (n_last) n_state = S_IDLE;
                    else n_idx = r_idx + 1'b1;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    n_ov = 1'b1;  n_ev = 1'b0;  n_ost = r_status;  n_ocnt = r_count;
                    n_olo = '0;  n_ohi = '0;  n_last = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_ev;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {2'b00, FIELD_BITS'(r_ohi), FIELD_BITS'(r_olo),
                            COUNT_BITS'(r_ocnt), r_ost};

    // The stored count never exceeds the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXC) else $error("range count above table depth");

    // A listed range always carries status OK.
    a_list_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ev) |-> (r_ost == ST_OK)) else $error("listed range with error status");

    // A result that is not a listed range ends its transaction group.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ev) |-> r_last) else $error("status result without last");

    // The count only changes while an operation is in progress.
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_IDLE && !$past(in_acc)) |-> $stable(r_count))
        else $error("count changed while idle");

endmodule

// ===== rtl/dist_table.sv =====
// ----------------------------------------------------------------------------
// Range table storage
// One write port and one registered read port holding range bounds.
// ----------------------------------------------------------------------------
module dist_table #(
    parameter int MAX_RANGES = 16,
    parameter int VALUE_BITS = 31,
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [VALUE_BITS-1:0] i_wlow,
    input  logic [VALUE_BITS-1:0] i_whigh,
    input  logic [AW-1:0]         i_raddr,
    output logic [VALUE_BITS-1:0] o_rlow,
    output logic [VALUE_BITS-1:0] o_rhigh
);

    logic [VALUE_BITS-1:0] r_low  [MAX_RANGES];
    logic [VALUE_BITS-1:0] r_high [MAX_RANGES];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_low[i_waddr]  <= i_wlow;
            r_high[i_waddr] <= i_whigh;
        end
    end

    // Registered read port; a read returns the contents before a same-cycle write.
    always_ff @(posedge i_clk) begin
        o_rlow  <= r_low[i_raddr];
        o_rhigh <= r_high[i_raddr];
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint interval set table testbench
// Drives insert, remove, invert, fill, clear and list transactions into the
// table with bursty input and a stalling output side, predicts every result
// from a local copy of the range table and compares each result field by
// field.
// ----------------------------------------------------------------------------
module tb;
    import dist_pkg::*;

    localparam logic [30:0] VMAX = 31'h7FFFFFFF;
    localparam int          DEPTH = 16;

    typedef struct {
        logic [2:0]  status;
        logic [4:0]  count;
        logic        valid;
        logic [30:0] lo;
        logic [30:0] hi;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // range_low[30:0], range_high[61:31]
    logic [2:0]  s_axis_tuser = '0;  // operation[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;       // status, range_count, entry_low, entry_high
    logic        m_axis_tuser;       // entry_valid
    logic        m_axis_tlast;

    // Local copy of the range table.
    logic [30:0] tbl_lo [DEPTH];
    logic [30:0] tbl_hi [DEPTH];
    int          tbl_cnt = 0;

    t_result     pending_q [$];
    int          errors = 0;
    int          hold_cycles = 0;
    int          burst_left = 0;

    disjoint_interval_set_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Table edits used by the range predictor.
    task automatic tbl_delete(int i);
        for (int j = i; j + 1 < tbl_cnt; j++) begin
            tbl_lo[j] = tbl_lo[j + 1];
            tbl_hi[j] = tbl_hi[j + 1];
        end
        tbl_cnt--;
    endtask

    task automatic tbl_insert(int i, logic [30:0] lo, logic [30:0] hi);
        for (int j = tbl_cnt; j > i; j--) begin
            tbl_lo[j] = tbl_lo[j - 1];
            tbl_hi[j] = tbl_hi[j - 1];
        end
        tbl_lo[i] = lo;
        tbl_hi[i] = hi;
        tbl_cnt++;
    endtask

    task automatic push_result(t_status st, logic v, logic [30:0] lo, logic [30:0] hi,
                               logic last);
        t_result r;
        r.status = st;
        r.count  = tbl_cnt[4:0];
        r.valid  = v;
        r.lo     = lo;
        r.hi     = hi;
        r.last   = last;
        pending_q.push_back(r);
    endtask

    // Updates the local table for one accepted transaction and queues its results.
    task automatic predict_ranges(logic [2:0] op, logic [30:0] lo, logic [30:0] hi);
        t_status     st;
        int          pos;
        int          g;
        bit          mp, mn, done;
        logic [31:0] cur;
        logic [30:0] top;
        logic [30:0] glo [DEPTH + 1];
        logic [30:0] ghi [DEPTH + 1];
        st = ST_OK;
        case (op)
            OP_INSERT: begin
                if (lo > hi) begin
                    st = ST_ORDER;
                end else begin
                    pos = 0;
                    while (pos < tbl_cnt && tbl_lo[pos] < lo) pos++;
                    if ((pos > 0 && tbl_hi[pos - 1] >= lo) ||
                        (pos < tbl_cnt && tbl_lo[pos] <= hi)) begin
                        st = ST_OVERLAP;
                    end else begin
                        mp = pos > 0 && {1'b0, tbl_hi[pos - 1]} + 32'd1 == {1'b0, lo};
                        mn = pos < tbl_cnt && {1'b0, hi} + 32'd1 == {1'b0, tbl_lo[pos]};
                        if (mp && mn) begin
                            tbl_hi[pos - 1] = tbl_hi[pos];
                            tbl_delete(pos);
                        end else if (mp) begin
                            tbl_hi[pos - 1] = hi;
                        end else if (mn) begin
                            tbl_lo[pos] = lo;
                        end else if (tbl_cnt >= DEPTH) begin
                            st = ST_FULL;
                        end else begin
                            tbl_insert(pos, lo, hi);
                        end
                    end
                end
            end
            OP_REMOVE: begin
                if (lo > hi) begin
                    st = ST_ORDER;
                end else begin
                    pos = 0;
                    while (pos < tbl_cnt && !(tbl_lo[pos] <= lo && hi <= tbl_hi[pos])) pos++;
                    if (pos >= tbl_cnt) begin
                        st = ST_NOT_CONTAINED;
                    end else if (tbl_lo[pos] == lo && tbl_hi[pos] == hi) begin
                        tbl_delete(pos);
                    end else if (tbl_lo[pos] == lo) begin
                        tbl_lo[pos] = hi + 31'd1;
                    end else if (tbl_hi[pos] == hi) begin
                        tbl_hi[pos] = lo - 31'd1;
                    end else if (tbl_cnt >= DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        top = tbl_hi[pos];
                        tbl_hi[pos] = lo - 31'd1;
                        tbl_insert(pos + 1, hi + 31'd1, top);
                    end
                end
            end
            OP_INVERT: begin
                g = 0;
                cur = '0;
                done = 0;
                for (int i = 0; i < tbl_cnt && !done; i++) begin
                    if ({1'b0, tbl_lo[i]} > cur) begin
                        glo[g] = cur[30:0];
                        ghi[g] = tbl_lo[i] - 31'd1;
                        g++;
                    end
                    if (tbl_hi[i] == VMAX) done = 1;
                    else cur = {1'b0, tbl_hi[i]} + 32'd1;
                end
                if (!done) begin
                    glo[g] = cur[30:0];
                    ghi[g] = VMAX;
                    g++;
                end
                if (g > DEPTH) begin
                    st = ST_FULL;
                end else begin
                    for (int i = 0; i < g; i++) begin
                        tbl_lo[i] = glo[i];
                        tbl_hi[i] = ghi[i];
                    end
                    tbl_cnt = g;
                end
            end
            OP_FILL: begin
                tbl_cnt = 0;
                tbl_insert(0, '0, VMAX);
            end
            OP_CLEAR: tbl_cnt = 0;
            OP_LIST: begin
                if (tbl_cnt > 0) begin
                    for (int i = 0; i < tbl_cnt; i++)
                        push_result(ST_OK, 1'b1, tbl_lo[i], tbl_hi[i], i + 1 == tbl_cnt);
                    return;
                end
            end
            default: ;
        endcase
        push_result(st, 1'b0, '0, '0, 1'b1);
    endtask

    // Sends one transaction, with a random gap between bursts, and predicts it.
    task automatic send_item(logic [2:0] op, logic [30:0] lo, logic [30:0] hi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {2'b00, hi, lo};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_ranges(op, lo, hi);
    endtask

    // Waits until every queued result has arrived, then lets the block settle.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [30:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return VMAX - 31'($urandom_range(0, 40));
            1:       return 31'($urandom);
            default: return 31'($urandom_range(0, 90));
        endcase
    endfunction

    // Receiver: random stall pattern, with an optional long hold.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (($urandom_range(0, 199) / 50) == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result transaction %h", m_axis_tdata);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (m_axis_tdata[2:0] !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[7:3] !== e.count) begin
                    $error("range_count exp %0d got %0d", e.count, m_axis_tdata[7:3]);
                    errors++;
                end
                if (m_axis_tuser !== e.valid) begin
                    $error("entry_valid exp %0d got %0d", e.valid, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[38:8] !== e.lo) begin
                    $error("entry_low exp %0h got %0h", e.lo, m_axis_tdata[38:8]);
                    errors++;
                end
                if (m_axis_tdata[69:39] !== e.hi) begin
                    $error("entry_high exp %0h got %0h", e.hi, m_axis_tdata[69:39]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Extremes, every operation and the order, overlap and not-contained error cases.
    task automatic test_directed();
        send_item(OP_LIST, '0, '0);
        send_item(OP_REMOVE, 31'd5, 31'd5);
        send_item(OP_INSERT, 31'd9, 31'd3);
        send_item(OP_REMOVE, 31'd9, 31'd3);
        send_item(3'd6, VMAX, VMAX);
        send_item(3'd7, '0, '0);
        send_item(OP_INVERT, '0, '0);
        send_item(OP_LIST, '0, '0);
        send_item(OP_INVERT, '0, '0);
        send_item(OP_INSERT, '0, '0);
        send_item(OP_INSERT, VMAX, VMAX);
        send_item(OP_INSERT, 31'd10, 31'd20);
        send_item(OP_INSERT, 31'd15, 31'd30);
        send_item(OP_INSERT, 31'd1, 31'd9);
        send_item(OP_REMOVE, 31'd5, 31'd50);
        send_item(OP_REMOVE, 31'd5, 31'd6);
        send_item(OP_REMOVE, '0, 31'd2);
        send_item(OP_REMOVE, 31'd18, 31'd20);
        send_item(OP_REMOVE, VMAX, VMAX);
        send_item(OP_LIST, '0, '0);
        send_item(OP_INVERT, '0, '0);
        send_item(OP_LIST, '0, '0);
        send_item(OP_FILL, '0, '0);
        send_item(OP_REMOVE, '0, VMAX);
        send_item(OP_CLEAR, '0, '0);
        wait_drained();
    endtask

    // Fills the table with single values and hits every table full case.
    task automatic test_table_full();
        for (int i = 0; i < DEPTH; i++)
            send_item(OP_INSERT, 31'(2 * i + 1), 31'(2 * i + 1));
        send_item(OP_INSERT, 31'd100, 31'd200);
        send_item(OP_INVERT, '0, '0);
        send_item(OP_LIST, '0, '0);
        send_item(OP_INSERT, 31'd2, 31'd2);
        send_item(OP_INSERT, 31'd100, 31'd200);
        send_item(OP_REMOVE, 31'd1, 31'd1);
        send_item(OP_INSERT, 31'd100, 31'd200);
        send_item(OP_REMOVE, 31'd150, 31'd160);
        send_item(OP_LIST, '0, '0);
        wait_drained();
    endtask

    // Mostly valid inserts and removes of stored sub-ranges, plus noise.
    task automatic test_random_ops(int n);
        int          k;
        logic [30:0] a, b, t;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                a = rand_value();
                b = ($urandom_range(0, 3) == 0) ? rand_value() : a + 31'($urandom_range(0, 6));
                if (b < a && $urandom_range(0, 3) != 0) begin
                    t = a; a = b; b = t;
                end
                send_item(OP_INSERT, a, b);
            end else if (k < 65 && tbl_cnt > 0) begin
                k = $urandom_range(0, tbl_cnt - 1);
                a = tbl_lo[k] + 31'($urandom_range(0, 3));
                b = tbl_hi[k] - 31'($urandom_range(0, 3));
                if (a > tbl_hi[k] || b < tbl_lo[k] || a > b) begin
                    a = tbl_lo[k];
                    b = tbl_hi[k];
                end
                send_item(OP_REMOVE, a, b);
            end else if (k < 72) begin
                send_item(OP_REMOVE, rand_value(), rand_value());
            end else if (k < 80) begin
                send_item(OP_LIST, 31'($urandom), 31'($urandom));
            end else if (k < 86) begin
                send_item(OP_INVERT, 31'($urandom), 31'($urandom));
            end else if (k < 89) begin
                send_item(OP_FILL, '0, '0);
            end else if (k < 93) begin
                send_item(OP_CLEAR, '0, '0);
            end else begin
                send_item(3'($urandom_range(0, 7)), 31'($urandom), 31'($urandom));
            end
        end
        wait_drained();
    endtask

    // Long receiver hold while the sender keeps offering list and invert transactions.
    task automatic test_backpressure();
        send_item(OP_CLEAR, '0, '0);
        for (int i = 0; i < 12; i++)
            send_item(OP_INSERT, 31'(10 * i), 31'(10 * i + 4));
        wait_drained();
        hold_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_item((i % 2) ? OP_INVERT : OP_LIST, '0, '0);
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_table_full();
        test_random_ops(150);
        test_backpressure();
        test_random_ops(150);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
